>>> src/hcb_pkg.sv
// Shared types and codes for the Huffman code builder.
package hcb_pkg;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_SATURATED = 3'd3;
    localparam logic [2:0] ST_NOT_BUILT = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        present;
        logic [2:0]  status;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [7:0] symbol;
    } t_cmd;

endpackage

>>> src/hcb_front.sv
// Input stage: accepts items, decodes the operation and queues commands.
module hcb_front import hcb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_data,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.op     = t_op'(i_data.op);
        cmd_in.symbol = i_data.symbol;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule

>>> src/hcb_back.sv
// Execution stage: histogram, tree construction, code tables and result register.
module hcb_back import hcb_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_WIDTH  = 20,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);
    localparam int SW        = $clog2(SYMBOL_COUNT);
    localparam int NC        = 2 * SYMBOL_COUNT - 1;
    localparam int NW        = $clog2(NC);
    localparam int WW        = COUNT_WIDTH + SW;
    localparam int DW        = SW;
    localparam int LEN_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b000000000001,
        S_CNT       = 12'b000000000010,
        S_QRY       = 12'b000000000100,
        S_SCAN      = 12'b000000001000,
        S_SCAN_END  = 12'b000000010000,
        S_MERGE     = 12'b000000100000,
        S_CD_RD     = 12'b000001000000,
        S_CD_W0     = 12'b000010000000,
        S_CD_W1     = 12'b000100000000,
        S_SWEEP     = 12'b001000000000,
        S_SWEEP_END = 12'b010000000000,
        S_DONE      = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [COUNT_WIDTH-1:0] cnt_mem [SYMBOL_COUNT];
    logic [WW-1:0]          w_mem [SYMBOL_COUNT-1];
    logic [2*NW-1:0]        ch_mem [SYMBOL_COUNT-1];
    logic [32+DW-1:0]       pd_mem [NC];
    logic [31:0]            code_mem [SYMBOL_COUNT];
    logic [5:0]             len_mem [SYMBOL_COUNT];

    logic [COUNT_WIDTH-1:0] cnt_rd, cnt_wd;
    logic [SW-1:0]          cnt_ra, cnt_wa;
    logic                   cnt_we;
    logic [WW-1:0]          w_rd, w_wd;
    logic [SW-1:0]          w_ra, w_wa;
    logic                   w_we;
    logic [2*NW-1:0]        ch_rd, ch_wd;
    logic [SW-1:0]          ch_ra, ch_wa;
    logic                   ch_we;
    logic [32+DW-1:0]       pd_rd, pd_wd;
    logic [NW-1:0]          pd_ra, pd_wa;
    logic                   pd_we;
    logic [31:0]            code_rd, code_wd;
    logic [5:0]             len_rd, len_wd;
    logic [SW-1:0]          tb_ra, tb_wa;
    logic                   tb_we;

    logic [SYMBOL_COUNT-1:0] r_cnt_vld;
    logic [SW:0]             r_nz;
    logic                    r_sat;
    logic                    r_codes_valid;
    logic [NC-1:0]           r_live;
    logic [NW-1:0]           r_next;
    logic [SW:0]             r_live_cnt;
    logic [NW-1:0]           r_idx;
    logic                    r_pv;
    logic [NW-1:0]           r_pidx;
    logic                    r_plive;
    logic                    r_f1, r_f2;
    logic [NW-1:0]           r_b1, r_b2;
    logic [WW-1:0]           r_w1, r_w2;
    logic [NW-1:0]           r_p;
    logic                    r_isroot;
    logic [NW-1:0]           r_c1;
    logic [31:0]             r_ppath;
    logic [DW-1:0]           r_pdep;
    logic [SW-1:0]           r_sw;
    logic                    r_sv;
    logic [SW-1:0]           r_sidx;
    logic                    r_too_long;
    logic                    r_single;
    logic [7:0]              r_sym;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [NW-1:0]          idx_off, next_off, p_off;
    logic [WW-1:0]          scan_w;
    logic [31:0]            par_path;
    logic [DW-1:0]          par_dep;
    logic [DW-1:0]          sw_dep;
    logic [COUNT_WIDTH-1:0] cnt_old;
    logic                   cmd_sym_ok;
    logic                   sym_vld;

    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign idx_off  = r_idx - NW'(SYMBOL_COUNT);
    assign next_off = r_next - NW'(SYMBOL_COUNT);
    assign p_off    = r_p - NW'(SYMBOL_COUNT);
    assign scan_w   = (int'(r_pidx) < SYMBOL_COUNT) ? WW'(cnt_rd) : w_rd;
    assign par_path = r_isroot ? 32'd0 : pd_rd[32+DW-1:DW];
    assign par_dep  = r_isroot ? '0 : pd_rd[DW-1:0];
    assign sw_dep   = r_single ? '0 : pd_rd[DW-1:0];
    assign sym_vld  = r_cnt_vld[r_sym[SW-1:0]];
    assign cnt_old  = sym_vld ? cnt_rd : '0;
    assign cmd_sym_ok = int'(i_cmd.symbol) < SYMBOL_COUNT;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid &&
                       ((i_cmd.op == OP_COUNT) || (i_cmd.op == OP_CLEAR) || !r_out_valid);

    always_comb begin
        cnt_ra  = r_idx[SW-1:0];
        cnt_we  = 1'b0;
        cnt_wa  = r_sym[SW-1:0];
        cnt_wd  = cnt_old + COUNT_WIDTH'(1);
        w_ra    = idx_off[SW-1:0];
        w_we    = (r_state == S_MERGE);
        w_wa    = next_off[SW-1:0];
        w_wd    = r_w1 + r_w2;
        ch_ra   = p_off[SW-1:0];
        ch_we   = (r_state == S_MERGE);
        ch_wa   = next_off[SW-1:0];
        ch_wd   = {r_b2, r_b1};
        pd_ra   = r_p;
        pd_we   = 1'b0;
        pd_wa   = ch_rd[NW-1:0];
        pd_wd   = {par_path[30:0], 1'b0, par_dep + DW'(1)};
        tb_ra   = i_cmd.symbol[SW-1:0];
        tb_we   = 1'b0;
        tb_wa   = r_sidx;
        code_wd = r_single ? 32'd0 : pd_rd[32+DW-1:DW];
        len_wd  = 6'(sw_dep);
        if (r_state == S_IDLE) begin
            cnt_ra = i_cmd.symbol[SW-1:0];
        end
        if (r_state == S_CNT) begin
            cnt_we = (cnt_old != COUNT_MAX);
        end
        if (r_state == S_CD_W0) begin
            pd_we = 1'b1;
        end
        if (r_state == S_CD_W1) begin
            pd_we = 1'b1;
            pd_wa = r_c1;
            pd_wd = {r_ppath[30:0], 1'b1, r_pdep + DW'(1)};
        end
        if (r_state == S_SWEEP) begin
            pd_ra = NW'(r_sw);
        end
        if (r_sv && r_cnt_vld[r_sidx] && !(int'(sw_dep) > LEN_LIMIT)) begin
            tb_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            w_mem[w_wa] <= w_wd;
        end
        w_rd <= w_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            ch_mem[ch_wa] <= ch_wd;
        end
        ch_rd <= ch_mem[ch_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pd_we) begin
            pd_mem[pd_wa] <= pd_wd;
        end
        pd_rd <= pd_mem[pd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tb_we) begin
            code_mem[tb_wa] <= code_wd;
            len_mem[tb_wa]  <= len_wd;
        end
        code_rd <= code_mem[tb_ra];
        len_rd  <= len_mem[tb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv && r_plive) begin
            if (!r_f1 || scan_w < r_w1) begin
                r_b2 <= r_b1;
                r_w2 <= r_w1;
                r_f2 <= r_f1;
                r_b1 <= r_pidx;
                r_w1 <= scan_w;
                r_f1 <= 1'b1;
            end else if (!r_f2 || scan_w < r_w2) begin
                r_b2 <= r_pidx;
                r_w2 <= scan_w;
                r_f2 <= 1'b1;
            end
        end
        if (r_sv && r_cnt_vld[r_sidx] && (int'(sw_dep) > LEN_LIMIT)) begin
            r_too_long <= 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_f1  <= 1'b0;
                r_f2  <= 1'b0;
                r_sym <= i_cmd.symbol;
                r_too_long <= 1'b0;
                r_single   <= (r_nz == (SW+1)'(1));
                r_live     <= NC'(r_cnt_vld);
                r_next     <= NW'(SYMBOL_COUNT);
                r_live_cnt <= r_nz;
                r_sw       <= '0;
            end
            S_SCAN: begin
                r_pidx  <= r_idx;
                r_plive <= r_live[r_idx];
                r_idx   <= r_idx + NW'(1);
            end
            S_MERGE: begin
                r_live[r_b1]   <= 1'b0;
                r_live[r_b2]   <= 1'b0;
                r_live[r_next] <= 1'b1;
                r_next     <= r_next + NW'(1);
                r_live_cnt <= r_live_cnt - (SW+1)'(1);
                r_p   <= r_next;
                r_idx <= '0;
                r_f1  <= 1'b0;
                r_f2  <= 1'b0;
            end
            S_CD_RD: begin
                r_isroot <= (r_p == r_next - NW'(1));
            end
            S_CD_W0: begin
                r_c1    <= ch_rd[2*NW-1:NW];
                r_ppath <= par_path;
                r_pdep  <= par_dep;
            end
            S_CD_W1: begin
                r_p <= r_p - NW'(1);
            end
            S_SWEEP: begin
                r_sidx <= r_sw;
                r_sw   <= r_sw + SW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt_vld     <= '0;
            r_nz          <= '0;
            r_sat         <= 1'b0;
            r_codes_valid <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pv          <= 1'b0;
            r_sv          <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.op)
                            OP_COUNT: begin
                                r_codes_valid <= 1'b0;
                                if (cmd_sym_ok) begin
                                    r_state <= S_CNT;
                                end
                            end
                            OP_CLEAR: begin
                                r_cnt_vld     <= '0;
                                r_nz          <= '0;
                                r_sat         <= 1'b0;
                                r_codes_valid <= 1'b0;
                            end
                            OP_BUILD: begin
                                r_codes_valid <= 1'b0;
                                if (r_nz == '0) begin
                                    r_out       <= '{32'd0, 6'd0, 1'b0, ST_EMPTY};
                                    r_out_valid <= 1'b1;
                                end else if (r_nz == (SW+1)'(1)) begin
                                    r_state <= S_SWEEP;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_QUERY: begin
                                if (!r_codes_valid) begin
                                    r_out       <= '{32'd0, 6'd0, 1'b0, ST_NOT_BUILT};
                                    r_out_valid <= 1'b1;
                                end else if (cmd_sym_ok) begin
                                    r_state <= S_QRY;
                                end else begin
                                    r_out <= '{32'd0, 6'd0, 1'b0,
                                               r_sat ? ST_SATURATED : ST_OK};
                                    r_out_valid <= 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CNT: begin
                    if (cnt_old == COUNT_MAX) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_cnt_vld[r_sym[SW-1:0]] <= 1'b1;
                        if (!sym_vld) begin
                            r_nz <= r_nz + (SW+1)'(1);
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_QRY: begin
                    if (sym_vld) begin
                        r_out <= '{code_rd, len_rd, 1'b1,
                                   r_sat ? ST_SATURATED : ST_OK};
                    end else begin
                        r_out <= '{32'd0, 6'd0, 1'b0,
                                   r_sat ? ST_SATURATED : ST_OK};
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_SCAN: begin
                    r_pv <= 1'b1;
                    if (r_idx == r_next - NW'(1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (r_live_cnt == (SW+1)'(2)) begin
                        r_state <= S_CD_RD;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_CD_RD: begin
                    r_state <= S_CD_W0;
                end
                S_CD_W0: begin
                    r_state <= S_CD_W1;
                end
                S_CD_W1: begin
                    if (r_p == NW'(SYMBOL_COUNT)) begin
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_CD_RD;
                    end
                end
                S_SWEEP: begin
                    r_sv <= 1'b1;
                    if (r_sw == SW'(SYMBOL_COUNT - 1)) begin
                        r_state <= S_SWEEP_END;
                    end
                end
                S_SWEEP_END: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_codes_valid <= !r_too_long;
                    r_out <= '{32'd0, 6'd0, 1'b0,
                               r_too_long ? ST_TOO_LONG :
                               (r_sat ? ST_SATURATED : ST_OK)};
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

>>> src/huffman_code_builder.sv
// Top level of the Huffman code builder.
//
// Input channel i_in_valid / o_in_stall / i_in_data carries an operation and a
// byte symbol. Count adds one to the symbol's histogram entry unless it is full,
// clear empties the histogram, build constructs the prefix codes and query
// reads one code back. Build and query each give one transfer on o_out_valid /
// i_out_stall / o_out_data; count and clear give none.
// A two-entry command queue sits in front of the execution engine.
// A count is a read-modify-write of the histogram memory in the engine; a query
// reads the code tables into the result register. A build with n present
// symbols runs a scan for the two lightest live nodes before each of the n-1
// merges, then a code walk down from the root over the merge nodes and a sweep
// over the whole symbol table.
// Reset clears the histogram at once through per-entry valid bits and marks
// the codes as not built; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register, counts
// and clears go on, and build or query waits until the result is taken.
module huffman_code_builder import hcb_pkg::*; #(
    parameter int SYMBOL_COUNT = 256,
    parameter int COUNT_WIDTH  = 20,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    hcb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_data      (i_in_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    hcb_back #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_stall     (i_out_stall)
    );
endmodule

>>> test/huffman_code_builder_tb.sv
// Self-checking testbench for the Huffman code builder with randomized traffic.
`timescale 1ns / 1ps

module huffman_code_builder_tb;
    import hcb_pkg::*;

    localparam int SYM_N     = 256;
    localparam int CNT_W     = 20;
    localparam int CODE_MAX  = 32;
    localparam int NODE_N    = 2 * SYM_N - 1;
    localparam int CNT_TOP   = (1 << CNT_W) - 1;
    localparam int LEN_LIM   = (CODE_MAX < 32) ? CODE_MAX : 32;
    localparam int CYCLE_CAP = 4000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    huffman_code_builder #(
        .SYMBOL_COUNT(SYM_N),
        .COUNT_WIDTH(CNT_W),
        .MAX_CODE_LEN(CODE_MAX)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always #5 i_clk = ~i_clk;

    int unsigned      hist[SYM_N];
    logic [31:0]      code_tab[SYM_N];
    logic [5:0]       len_tab[SYM_N];
    bit               codes_ok;
    bit               sat_seen;
    bit               live[NODE_N];
    longint unsigned  weight[NODE_N];

    t_out_item pending_results[$];
    int        error_count;
    int        checked_count;
    int        build_count;
    int        query_count;
    int        count_items;
    int        cycle_count;
    bit        no_gaps;
    int        out_stall_left;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_lightest(int limit);
        int i;
        int best;
        bit found;
        best = 0;
        found = 1'b0;
        for (i = 0; i < limit; i++) begin
            if (live[i] && (!found || weight[i] < weight[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic logic [2:0] predict_build();
        longint unsigned path[NODE_N];
        int              dep[NODE_N];
        int              kids[SYM_N][2];
        int              i, k, c, p, a, b, nxt, nlive;
        bit              too_long;
        nlive = 0;
        nxt = SYM_N;
        too_long = 1'b0;
        for (i = 0; i < NODE_N; i++) begin
            live[i] = 1'b0;
            path[i] = 0;
            dep[i] = 0;
        end
        for (i = 0; i < SYM_N; i++) begin
            weight[i] = hist[i];
            if (hist[i] != 0) begin
                live[i] = 1'b1;
                nlive++;
            end
            code_tab[i] = '0;
            len_tab[i] = '0;
        end
        codes_ok = 1'b0;
        if (nlive == 0) return ST_EMPTY;
        while (nlive > 1 && nxt < NODE_N) begin
            a = pick_lightest(nxt);
            live[a] = 1'b0;
            b = pick_lightest(nxt);
            live[b] = 1'b0;
            weight[nxt] = weight[a] + weight[b];
            kids[nxt - SYM_N][0] = a;
            kids[nxt - SYM_N][1] = b;
            live[nxt] = 1'b1;
            nxt++;
            nlive--;
        end
        for (p = nxt - 1; p >= SYM_N; p--) begin
            for (k = 0; k < 2; k++) begin
                c = kids[p - SYM_N][k];
                dep[c] = dep[p] + 1;
                path[c] = (path[p] << 1) | longint'(k);
            end
        end
        for (i = 0; i < SYM_N; i++) begin
            if (hist[i] != 0) begin
                if (dep[i] > LEN_LIM) too_long = 1'b1;
                else begin
                    code_tab[i] = path[i][31:0];
                    len_tab[i] = dep[i][5:0];
                end
            end
        end
        if (too_long) begin
            for (i = 0; i < SYM_N; i++) begin
                code_tab[i] = '0;
                len_tab[i] = '0;
            end
            return ST_TOO_LONG;
        end
        codes_ok = 1'b1;
        return sat_seen ? ST_SATURATED : ST_OK;
    endfunction

    task automatic apply_to_model(t_in_item it);
        t_out_item r;
        r = '0;
        case (t_op'(it.op))
            OP_COUNT: begin
                codes_ok = 1'b0;
                count_items++;
                if (hist[it.symbol] >= CNT_TOP) begin
                    hist[it.symbol] = CNT_TOP;
                    sat_seen = 1'b1;
                end else hist[it.symbol]++;
            end
            OP_CLEAR: begin
                for (int i = 0; i < SYM_N; i++) hist[i] = 0;
                sat_seen = 1'b0;
                codes_ok = 1'b0;
            end
            OP_BUILD: begin
                build_count++;
                r.status = predict_build();
                pending_results = {pending_results, r};
            end
            default: begin
                query_count++;
                if (!codes_ok) r.status = ST_NOT_BUILT;
                else begin
                    if (hist[it.symbol] != 0) begin
                        r.code_bits = code_tab[it.symbol];
                        r.code_length = len_tab[it.symbol];
                        r.present = 1'b1;
                    end
                    r.status = sat_seen ? ST_SATURATED : ST_OK;
                end
                pending_results = {pending_results, r};
            end
        endcase
    endtask

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(t_op op, logic [7:0] sym);
        t_in_item it;
        int gap;
        it.op = op;
        it.symbol = sym;
        gap = random_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_to_model(it);
    endtask

    task automatic park_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_for_results();
        park_input();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && !i_out_stall) begin
            checked_count++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.code_bits !== want.code_bits) begin
                    $display("%0t code_bits: expected %h, actual %h",
                             $time, want.code_bits, o_out_data.code_bits);
                    error_count++;
                end
                if (o_out_data.code_length !== want.code_length) begin
                    $display("%0t code_length: expected %0d, actual %0d",
                             $time, want.code_length, o_out_data.code_length);
                    error_count++;
                end
                if (o_out_data.present !== want.present) begin
                    $display("%0t present: expected %b, actual %b",
                             $time, want.present, o_out_data.present);
                    error_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, o_out_data.status);
                    error_count++;
                end
            end
        end
        if (out_stall_left > 0) begin
            out_stall_left--;
            i_out_stall <= 1'b1;
        end else if (no_gaps || $urandom_range(0, 99) < 70) begin
            i_out_stall <= 1'b0;
        end else begin
            out_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end
    end

    task automatic test_basic_cases();
        send_item(OP_QUERY, 8'd5);
        send_item(OP_BUILD, 8'd0);
        send_item(OP_COUNT, 8'd0);
        send_item(OP_BUILD, 8'd0);
        send_item(OP_QUERY, 8'd0);
        send_item(OP_QUERY, 8'd255);
        send_item(OP_COUNT, 8'd255);
        send_item(OP_COUNT, 8'd255);
        send_item(OP_COUNT, 8'hAA);
        send_item(OP_COUNT, 8'h55);
        send_item(OP_QUERY, 8'd0);
        send_item(OP_BUILD, 8'd0);
        send_item(OP_QUERY, 8'd0);
        send_item(OP_QUERY, 8'd255);
        send_item(OP_QUERY, 8'hAA);
        send_item(OP_QUERY, 8'h55);
        send_item(OP_QUERY, 8'd1);
        send_item(OP_CLEAR, 8'd0);
        send_item(OP_QUERY, 8'd255);
        send_item(OP_BUILD, 8'd0);
    endtask

    task automatic test_long_codes();
        int fa, fb, ft;
        send_item(OP_CLEAR, 8'd0);
        fa = 1;
        fb = 1;
        for (int s = 10; s < 22; s++) begin
            repeat (fa) send_item(OP_COUNT, 8'(s));
            ft = fa + fb;
            fa = fb;
            fb = ft;
        end
        send_item(OP_BUILD, 8'd0);
        send_item(OP_QUERY, 8'd10);
        send_item(OP_QUERY, 8'd21);
    endtask

    task automatic test_full_alphabet();
        send_item(OP_CLEAR, 8'd0);
        for (int s = 0; s < SYM_N; s++) send_item(OP_COUNT, 8'(s));
        send_item(OP_BUILD, 8'd0);
        send_item(OP_QUERY, 8'd0);
        send_item(OP_QUERY, 8'd128);
        send_item(OP_QUERY, 8'd255);
    endtask

    task automatic test_random_traffic(int target);
        logic [7:0] alphabet[16];
        int n, used;
        used = 0;
        while (used < target) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            for (int i = 0; i < n; i++) alphabet[i] = 8'($urandom_range(0, 255));
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            used++;
            repeat ($urandom_range(n, 4 * n + 6)) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                else
                    send_item(OP_COUNT, alphabet[$urandom_range(0, n - 1)]);
                used++;
            end
            if ($urandom_range(0, 5) == 0) wait_for_results();
            send_item(OP_BUILD, 8'($urandom_range(0, 255)));
            used++;
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_QUERY, 8'($urandom_range(0, 255)));
                else
                    send_item(OP_QUERY, alphabet[$urandom_range(0, n - 1)]);
                used++;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < SYM_N; i++) begin
            hist[i] = 0;
            code_tab[i] = '0;
            len_tab[i] = '0;
        end
        codes_ok = 1'b0;
        sat_seen = 1'b0;
        error_count = 0;
        checked_count = 0;
        build_count = 0;
        query_count = 0;
        count_items = 0;
        cycle_count = 0;
        no_gaps = 1'b0;
        out_stall_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_cases();
        wait_for_results();
        test_long_codes();
        test_full_alphabet();
        test_random_traffic(1000);

        wait_for_results();
        repeat (300) @(posedge i_clk);
        $display("Checked %0d results from %0d builds and %0d queries over %0d counts,",
                 checked_count, build_count, query_count, count_items);
        $display("covering empty, single-symbol, deep and full-alphabet trees under stalls.");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
